// ===== hw/rtl/slotalloc_pkg.sv =====
// Shared types and constants for the slot allocator with free FIFO.
// Used by slotalloc_ctrl and slot_allocator_with_free_fifo_top; no dependencies.
`default_nettype none

package slotalloc_pkg;

    // Slot space and derived widths
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = 8;
    localparam int PTR_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = PTR_W + 1;
    localparam int CFG_W      = 9;

    localparam logic [CFG_W-1:0] MAX_SLOTS_RESET = CFG_W'(256);

    // Request kinds carried in s_axis_tuser
    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Result status carried in m_axis_tuser
    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] release_slot;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot_index;
    } res_t;

    // Internal occupancy, exported for checking
    typedef struct packed {
        logic [CNT_W-1:0] fifo_count;
        logic [CNT_W-1:0] next_fresh;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slotalloc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the free-slot FIFO entries.
`default_nettype none

module slotalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slotalloc_ctrl.sv =====
// Sequencer for the slot allocator: bump counter, FIFO pointers, duplicate scan
// with one shared comparator, and the result register. Depends on slotalloc_pkg.
`default_nettype none

module slotalloc_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire slotalloc_pkg::req_t        in_req,
    input  wire logic [slotalloc_pkg::CFG_W-1:0] max_slots,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output slotalloc_pkg::res_t             out_res,
    output slotalloc_pkg::stat_t            stat,
    output logic                            ram_wr_en,
    output logic [slotalloc_pkg::PTR_W-1:0] ram_wr_addr,
    output logic [slotalloc_pkg::SLOT_W-1:0] ram_wr_data,
    output logic [slotalloc_pkg::PTR_W-1:0] ram_rd_addr,
    input  wire logic [slotalloc_pkg::SLOT_W-1:0] ram_rd_data
);

    import slotalloc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic [PTR_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0] rel_reg, rel_next;
    res_t              res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;

    logic [CNT_W-1:0]  limit;
    logic              hit;
    logic              scan_last;

    // Effective limit: anything above the slot space acts as the slot space
    assign limit = (CNT_W'(max_slots) > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                            : CNT_W'(max_slots);

    // Shared compare unit: pending entry against the slot being released
    assign hit       = (ram_rd_data == rel_reg);
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign stat      = '{fifo_count: count_reg, next_fresh: fresh_reg};

    // Read address runs one entry ahead of the compare during a scan
    assign ram_rd_addr = (state_reg == S_SCAN)
                       ? PTR_W'(head_reg + scan_idx_reg + PTR_W'(1))
                       : head_reg;
    assign ram_wr_addr = tail_reg;
    assign ram_wr_data = (state_reg == S_IDLE) ? in_req.release_slot : rel_reg;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        fresh_next     = fresh_reg;
        scan_idx_next  = scan_idx_reg;
        rel_next       = rel_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        ram_wr_en      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rel_next = in_req.release_slot;
                    if (in_req.mode == MODE_ALLOC)
                    begin
                        if (count_reg != '0)
                        begin
                            // head entry read is already under way
                            state_next = S_ALLOC;
                        end
                        else if (fresh_reg < limit)
                        begin
                            res_next   = '{status: ST_ALLOCATED,
                                           slot_index: fresh_reg[SLOT_W-1:0]};
                            fresh_next = fresh_reg + CNT_W'(1);
                            state_next = S_RESP;
                        end
                        else
                        begin
                            res_next   = '{status: ST_EXHAUSTED, slot_index: '0};
                            state_next = S_RESP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // nothing pending: append without a scan
                        ram_wr_en  = 1'b1;
                        tail_next  = tail_reg + PTR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{status: ST_RELEASED, slot_index: '0};
                        state_next = S_RESP;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_ALLOC:
            begin
                res_next   = '{status: ST_ALLOCATED, slot_index: ram_rd_data};
                head_next  = head_reg + PTR_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESP;
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    res_next   = '{status: ST_IGNORED, slot_index: '0};
                    state_next = S_RESP;
                end
                else if (scan_last)
                begin
                    if (count_reg == CNT_W'(SLOT_COUNT))
                    begin
                        // full FIFO drops the release
                        res_next = '{status: ST_IGNORED, slot_index: '0};
                    end
                    else
                    begin
                        ram_wr_en  = 1'b1;
                        tail_next  = tail_reg + PTR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{status: ST_RELEASED, slot_index: '0};
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + PTR_W'(1);
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            scan_idx_reg  <= '0;
            rel_reg       <= '0;
            res_reg       <= '{status: ST_ALLOCATED, slot_index: '0};
            out_valid_reg <= 1'b0;
            out_res_reg   <= '{status: ST_ALLOCATED, slot_index: '0};
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            scan_idx_reg  <= scan_idx_next;
            rel_reg       <= rel_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/slot_allocator_with_free_fifo_top.sv =====
// Top level of the slot allocator: stream ports, max_slots register, FIFO RAM.
// Depends on slotalloc_pkg, slotalloc_ram and slotalloc_ctrl.
`default_nettype none

// Hands out slot numbers 0..255. An allocate request (tuser = 0) reuses the
// oldest released slot from the free FIFO, else takes the next fresh slot
// from a bump counter limited by max_slots, else reports exhausted. A release
// request (tuser = 1, slot in tdata) is appended to the FIFO unless it is
// already pending or the FIFO is full. The block takes one request at a time:
// an allocate goes from accept straight to the result, or through S_ALLOC when it
// reuses a FIFO entry; a release with entries pending first runs the duplicate
// scan, which reads one pending FIFO entry per cycle through the single RAM
// read port and checks it with one comparator. A result waits in an output
// register, so s_axis_tready comes back while it is still untaken.
// max_slots resets to 256; write it only while the block is idle.

module slot_allocator_with_free_fifo_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] release_slot
    input  wire logic        s_axis_tuser,   // [0] mode
    // Results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] slot_index
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    // max_slots register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);

    import slotalloc_pkg::*;

    logic [CFG_W-1:0]  max_slots_reg;
    req_t              req;
    res_t              res;
    stat_t             stat;
    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    logic [SLOT_W-1:0] ram_wr_data;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [SLOT_W-1:0] ram_rd_data;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_slots_reg <= MAX_SLOTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_slots_reg <= cfg_data;
        end
    end

    assign req = '{mode: s_axis_tuser, release_slot: s_axis_tdata};

    slotalloc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req      (req),
        .max_slots   (max_slots_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (res),
        .stat        (stat),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    slotalloc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_fifo_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tdata = res.slot_index;
    assign m_axis_tuser = res.status;

    // Checks
    // one request in flight: the sequencer drops ready after each transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while a previous one is in progress");

    // only a successful allocation carries a nonzero slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (res.status != ST_ALLOCATED)) |-> (res.slot_index == '0))
        else $error("nonzero slot on a non-allocation result");

    // occupancy never exceeds the slot space
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.fifo_count <= CNT_W'(SLOT_COUNT)) && (stat.next_fresh <= CNT_W'(SLOT_COUNT)))
        else $error("FIFO count or fresh counter out of range");

endmodule

`default_nettype wire
